FILE: hdl/deq_pkg.sv
package deq_pkg;

  localparam int SLOTS       = 16;
  localparam int HANDLE_BITS = 16;

  localparam int FUNC_W  = 2;
  localparam int HND_W   = 16;
  localparam int TIME_W  = 64;
  localparam int KIND_W  = 2;
  localparam int ORDER_W = 32;
  localparam int SLOT_W  = $clog2(SLOTS);
  localparam int CNT_W   = $clog2(SLOTS + 1);

  // only the low HANDLE_BITS of a handle count
  localparam logic [HND_W-1:0] HANDLE_MASK =
    HND_W'((65'(1) << HANDLE_BITS) - 65'(1));

  localparam logic [FUNC_W-1:0] FN_AT     = 2'd0;
  localparam logic [FUNC_W-1:0] FN_AFTER  = 2'd1;
  localparam logic [FUNC_W-1:0] FN_CANCEL = 2'd2;
  localparam logic [FUNC_W-1:0] FN_TICK   = 2'd3;

  localparam logic [KIND_W-1:0] KD_EXPIRED = 2'd0;
  localparam logic [KIND_W-1:0] KD_SCHED   = 2'd1;
  localparam logic [KIND_W-1:0] KD_CANCEL  = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ADD,
    ST_SCAN,
    ST_DONE
  } state_t;

endpackage

FILE: hdl/deq_if.sv
interface deq_in_if;
  logic                        valid;
  logic                        ready;
  logic [deq_pkg::FUNC_W-1:0]  func;
  logic [deq_pkg::HND_W-1:0]   handle;
  logic [deq_pkg::TIME_W-1:0]  deadline_ns;
  logic [deq_pkg::TIME_W-1:0]  delay_ns;
  logic [deq_pkg::TIME_W-1:0]  now_ns;

  modport source (output valid, func, handle, deadline_ns, delay_ns, now_ns, input ready);
  modport sink   (input valid, func, handle, deadline_ns, delay_ns, now_ns, output ready);
endinterface

interface deq_out_if;
  logic                        valid;
  logic                        ready;
  logic [deq_pkg::KIND_W-1:0]  kind;
  logic [deq_pkg::HND_W-1:0]   event_id;
  logic                        ok;
  logic                        last;

  modport source (output valid, kind, event_id, ok, last, input ready);
  modport sink   (input valid, kind, event_id, ok, last, output ready);
endinterface

FILE: hdl/deadline_event_queue.sv
// schedule at deadline / cancel: result registered after the full slot scan
// schedule after delay: an extra state before the scan does the saturating add
// tick: a full slot scan for each released event, which is the earliest due one
// (older wins on equal deadlines); rescans until none remain; no result if none due
// one request in work at a time, set by the scan; ready returns with any last result
// reset clears slot occupancy and the insert counter directly, no sweep
module deadline_event_queue (
  input logic clk,
  input logic rst_n,
  deq_in_if.sink    in_ch,
  deq_out_if.source out_ch
);
  import deq_pkg::*;

  state_t state_r, state_nxt;

  logic [SLOTS-1:0]   slot_valid_r;
  logic [TIME_W-1:0]  slot_dl_r  [SLOTS];
  logic [HND_W-1:0]   slot_hnd_r [SLOTS];
  logic [ORDER_W-1:0] slot_ord_r [SLOTS];
  logic [ORDER_W-1:0] ins_cnt_r, ins_cnt_nxt;

  logic [FUNC_W-1:0] func_r, func_nxt;
  logic [HND_W-1:0]  hnd_r, hnd_nxt;
  logic [TIME_W-1:0] when_r, when_nxt;
  logic [TIME_W-1:0] dly_r, dly_nxt;

  logic [SLOT_W-1:0]  idx_r, idx_nxt;
  logic               hit_r, hit_nxt;
  logic [SLOT_W-1:0]  hit_idx_r, hit_idx_nxt;
  logic               free_r, free_nxt;
  logic [SLOT_W-1:0]  free_idx_r, free_idx_nxt;
  logic               found_r, found_nxt;
  logic [SLOT_W-1:0]  best_idx_r, best_idx_nxt;
  logic [TIME_W-1:0]  best_dl_r, best_dl_nxt;
  logic [ORDER_W-1:0] best_age_r, best_age_nxt;
  logic [HND_W-1:0]   best_hnd_r, best_hnd_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [KIND_W-1:0] kind_r, kind_nxt;
  logic [HND_W-1:0]  id_r, id_nxt;
  logic              ok_r, ok_nxt;
  logic              last_r, last_nxt;

  logic               rd_v;
  logic [TIME_W-1:0]  rd_dl;
  logic [HND_W-1:0]   rd_hnd;
  logic [ORDER_W-1:0] rd_age;
  logic               rd_due;
  logic               rd_better;
  logic [TIME_W:0]    sum;
  logic               out_free;
  logic               scan_clr;
  logic               slot_we;
  logic               slot_clr;
  logic [SLOT_W-1:0]  clr_idx;
  logic               sched_ok;

  assign rd_v      = slot_valid_r[idx_r];
  assign rd_dl     = slot_dl_r[idx_r];
  assign rd_hnd    = slot_hnd_r[idx_r];
  assign rd_age    = ins_cnt_r - slot_ord_r[idx_r];
  assign rd_due    = rd_v && (rd_dl <= when_r);
  // strict compare keeps the lowest slot on a full tie
  assign rd_better = !found_r || (rd_dl < best_dl_r) ||
                     ((rd_dl == best_dl_r) && (rd_age > best_age_r));
  assign sum       = {1'b0, when_r} + {1'b0, dly_r};
  assign out_free  = !out_valid_r || out_ch.ready;
  assign sched_ok  = !hit_r && free_r;

  assign in_ch.ready     = (state_r == ST_IDLE);
  assign out_ch.valid    = out_valid_r;
  assign out_ch.kind     = kind_r;
  assign out_ch.event_id = id_r;
  assign out_ch.ok       = ok_r;
  assign out_ch.last     = last_r;

  always_comb begin
    state_nxt     = state_r;
    ins_cnt_nxt   = ins_cnt_r;
    func_nxt      = func_r;
    hnd_nxt       = hnd_r;
    when_nxt      = when_r;
    dly_nxt       = dly_r;
    idx_nxt       = idx_r;
    hit_nxt       = hit_r;
    hit_idx_nxt   = hit_idx_r;
    free_nxt      = free_r;
    free_idx_nxt  = free_idx_r;
    found_nxt     = found_r;
    best_idx_nxt  = best_idx_r;
    best_dl_nxt   = best_dl_r;
    best_age_nxt  = best_age_r;
    best_hnd_nxt  = best_hnd_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    kind_nxt      = kind_r;
    id_nxt        = id_r;
    ok_nxt        = ok_r;
    last_nxt      = last_r;
    scan_clr      = 1'b0;
    slot_we       = 1'b0;
    slot_clr      = 1'b0;
    clr_idx       = hit_idx_r;

    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          func_nxt = in_ch.func;
          hnd_nxt  = in_ch.handle & HANDLE_MASK;
          dly_nxt  = in_ch.delay_ns;
          when_nxt = (in_ch.func == FN_AT) ? in_ch.deadline_ns : in_ch.now_ns;
          scan_clr = 1'b1;
          state_nxt = (in_ch.func == FN_AFTER) ? ST_ADD : ST_SCAN;
        end
      end
      ST_ADD: begin
        // saturate at the largest time
        when_nxt  = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
        state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (rd_v && (rd_hnd == hnd_r) && !hit_r) begin
          hit_nxt     = 1'b1;
          hit_idx_nxt = idx_r;
        end
        if (!rd_v && !free_r) begin
          free_nxt     = 1'b1;
          free_idx_nxt = idx_r;
        end
        if (rd_due) begin
          cnt_nxt = cnt_r + CNT_W'(1);
          if (rd_better) begin
            found_nxt    = 1'b1;
            best_idx_nxt = idx_r;
            best_dl_nxt  = rd_dl;
            best_age_nxt = rd_age;
            best_hnd_nxt = rd_hnd;
          end
        end
        idx_nxt = idx_r + SLOT_W'(1);
        if (idx_r == SLOT_W'(SLOTS - 1)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (func_r == FN_TICK && !found_r) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
          case (func_r)
            FN_AT, FN_AFTER: begin
              kind_nxt = KD_SCHED;
              id_nxt   = hnd_r;
              ok_nxt   = sched_ok;
              last_nxt = 1'b1;
              if (sched_ok) begin
                slot_we     = 1'b1;
                ins_cnt_nxt = ins_cnt_r + ORDER_W'(1);
              end
            end
            FN_CANCEL: begin
              kind_nxt = KD_CANCEL;
              id_nxt   = hnd_r;
              ok_nxt   = hit_r;
              last_nxt = 1'b1;
              slot_clr = hit_r;
            end
            default: begin
              kind_nxt = KD_EXPIRED;
              id_nxt   = best_hnd_r;
              ok_nxt   = 1'b0;
              last_nxt = (cnt_r == CNT_W'(1));
              slot_clr = 1'b1;
              clr_idx  = best_idx_r;
              // the due count of this scan tells whether more remain
              if (cnt_r != CNT_W'(1)) begin
                scan_clr  = 1'b1;
                state_nxt = ST_SCAN;
              end
            end
          endcase
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (scan_clr) begin
      idx_nxt   = '0;
      hit_nxt   = 1'b0;
      free_nxt  = 1'b0;
      found_nxt = 1'b0;
      cnt_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_valid_r  <= 1'b0;
      slot_valid_r <= '0;
      ins_cnt_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      ins_cnt_r   <= ins_cnt_nxt;
      if (slot_we) begin
        slot_valid_r[free_idx_r] <= 1'b1;
      end
      if (slot_clr) begin
        slot_valid_r[clr_idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot_dl_r[free_idx_r]  <= when_r;
      slot_hnd_r[free_idx_r] <= hnd_r;
      slot_ord_r[free_idx_r] <= ins_cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    func_r     <= func_nxt;
    hnd_r      <= hnd_nxt;
    when_r     <= when_nxt;
    dly_r      <= dly_nxt;
    idx_r      <= idx_nxt;
    hit_r      <= hit_nxt;
    hit_idx_r  <= hit_idx_nxt;
    free_r     <= free_nxt;
    free_idx_r <= free_idx_nxt;
    found_r    <= found_nxt;
    best_idx_r <= best_idx_nxt;
    best_dl_r  <= best_dl_nxt;
    best_age_r <= best_age_nxt;
    best_hnd_r <= best_hnd_nxt;
    cnt_r      <= cnt_nxt;
    kind_r     <= kind_nxt;
    id_r       <= id_nxt;
    ok_r       <= ok_nxt;
    last_r     <= last_nxt;
  end

endmodule
